// ===== hw/rtl/sld_pkg.sv =====
package sld_pkg;

    localparam int MAX_PAYLOAD_DEFAULT = 256;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_EXPECTED = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET     = 8'h6D;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET    = 8'h62;
    localparam logic [WORD_W-1:0] CHECK_EXPECTED_RESET = 16'hCACB;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABORTED  = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [WORD_W-1:0] check_expected;
    } cfg_t;

    typedef struct packed {
        logic                item_kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic [BYTE_W-1:0]   byte_index;
        logic [WORD_W-1:0]   command_id;
        logic [WORD_W-1:0]   frame_length;
        logic [STATUS_W-1:0] frame_status;
        logic                frame_last;
    } result_t;

endpackage

// ===== hw/rtl/sld_cfg_regs.sv =====
module sld_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sld_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output sld_pkg::cfg_t                  cfg
);
    import sld_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first     <= SYNC_FIRST_RESET;
            cfg_reg.sync_second    <= SYNC_SECOND_RESET;
            cfg_reg.check_expected <= CHECK_EXPECTED_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:     cfg_reg.sync_first     <= cfg_wr_data[BYTE_W-1:0];
                CFG_SYNC_SECOND:    cfg_reg.sync_second    <= cfg_wr_data[BYTE_W-1:0];
                CFG_CHECK_EXPECTED: cfg_reg.check_expected <= cfg_wr_data[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/sld_parser.sv =====
module sld_parser #(
    parameter int MAX_PAYLOAD = sld_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    input  logic [sld_pkg::BYTE_W-1:0] in_byte,
    input  sld_pkg::cfg_t              cfg,
    output logic                       res_valid,
    output sld_pkg::result_t           res
);
    import sld_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD);
    localparam logic [WORD_W-1:0] LIMIT = WORD_W'(MAX_PAYLOAD - 2);

    localparam logic [3:0] PH_HUNT  = 4'd0;
    localparam logic [3:0] PH_SYNC2 = 4'd1;
    localparam logic [3:0] PH_CMD0  = 4'd2;
    localparam logic [3:0] PH_CMD1  = 4'd3;
    localparam logic [3:0] PH_LEN0  = 4'd4;
    localparam logic [3:0] PH_LEN1  = 4'd5;
    localparam logic [3:0] PH_DATA  = 4'd6;
    localparam logic [3:0] PH_CHK0  = 4'd7;
    localparam logic [3:0] PH_CHK1  = 4'd8;

    logic [3:0]        phase_reg, phase_next;
    logic [WORD_W-1:0] cmd_reg, cmd_next;
    logic [WORD_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] chk_low_reg, chk_low_next;
    logic [WORD_W-1:0] count_ext;
    logic [WORD_W-1:0] len_full;
    logic              take_data;

    assign count_ext = WORD_W'(count_reg);
    assign len_full  = {in_byte, len_reg[BYTE_W-1:0]};
    assign take_data = (count_ext < len_reg) && (count_ext < LIMIT);

    always_comb begin
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        chk_low_next = chk_low_reg;
        res_valid    = 1'b0;
        res          = '0;
        unique case (phase_reg)
            PH_SYNC2: begin
                phase_next = (in_byte == cfg.sync_second) ? PH_CMD0 : PH_HUNT;
            end
            PH_CMD0: begin
                cmd_next   = WORD_W'(in_byte);
                phase_next = PH_CMD1;
            end
            PH_CMD1: begin
                cmd_next   = {in_byte, cmd_reg[BYTE_W-1:0]};
                phase_next = PH_LEN0;
            end
            PH_LEN0: begin
                len_next   = WORD_W'(in_byte);
                phase_next = PH_LEN1;
            end
            PH_LEN1: begin
                len_next   = len_full;
                phase_next = (len_full == '0) ? PH_CHK0 : PH_DATA;
            end
            PH_DATA: begin
                res_valid = 1'b1;
                if (take_data) begin
                    res.item_kind    = KIND_DATA;
                    res.payload_byte = in_byte;
                    res.byte_index   = BYTE_W'(count_reg);
                    count_next       = CNT_W'(count_ext + 1'b1);
                    if (count_ext + 1'b1 == len_reg) begin
                        phase_next = PH_CHK0;
                    end
                end else begin
                    // drop the byte and close the frame
                    res.item_kind    = KIND_END;
                    res.command_id   = cmd_reg;
                    res.frame_length = len_reg;
                    res.frame_status = STATUS_ABORTED;
                    res.frame_last   = 1'b1;
                    phase_next       = PH_HUNT;
                end
            end
            PH_CHK0: begin
                chk_low_next = in_byte;
                phase_next   = PH_CHK1;
            end
            PH_CHK1: begin
                res_valid        = 1'b1;
                res.item_kind    = KIND_END;
                res.command_id   = cmd_reg;
                res.frame_length = len_reg;
                res.frame_status = ({in_byte, chk_low_reg} == cfg.check_expected) ?
                                   STATUS_GOOD : STATUS_MISMATCH;
                res.frame_last   = 1'b1;
                phase_next       = PH_HUNT;
            end
            default: begin
                if (in_byte == cfg.sync_first) begin
                    cmd_next   = '0;
                    len_next   = '0;
                    count_next = '0;
                    phase_next = PH_SYNC2;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
        if (!in_valid) begin
            phase_next   = phase_reg;
            cmd_next     = cmd_reg;
            len_next     = len_reg;
            count_next   = count_reg;
            chk_low_next = chk_low_reg;
            res_valid    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            cmd_reg     <= '0;
            len_reg     <= '0;
            count_reg   <= '0;
            chk_low_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            cmd_reg     <= cmd_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
            chk_low_reg <= chk_low_next;
        end
    end

    a_count_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        WORD_W'(count_reg) <= LIMIT)
        else $error("payload count beyond limit");

    a_data_has_length: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> len_reg != '0)
        else $error("payload phase with zero length");

    a_check_closes_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && phase_reg == PH_CHK1 |-> res_valid && res.item_kind == KIND_END)
        else $error("second check byte gave no frame end");

    a_index_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.item_kind == KIND_DATA
        |=> count_reg == CNT_W'(WORD_W'($past(count_reg)) + 1'b1))
        else $error("payload index did not advance");

endmodule

// ===== hw/rtl/sld_out_reg.sv =====
module sld_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  sld_pkg::result_t in_res,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output sld_pkg::result_t out_res
);
    import sld_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= in_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== hw/rtl/sync_length_frame_deframer.sv =====
// Sync-header, length-prefixed frame deframer.
// Input channel (s_valid/s_ready/s_rx_byte) takes one received byte per beat.
// The block hunts for the two sync bytes, reads a little-endian command id
// and length, streams the payload, then reads a two-byte check word.
// Result channel (m_*) carries one beat per payload byte (with its index) and
// one frame-end beat with command, length and status after the last check
// byte, or when a payload overruns MAX_PAYLOAD - 2 bytes (that byte is dropped).
// Configuration writes (cfg_wr_en/cfg_index/cfg_wr_data) take effect at once;
// issue them only while the block is idle.
// A result is registered and appears on m_* in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output is not stalled, set by the parse
// state machine feeding one output register.
// Stall: with the output register full and m_ready low, s_ready drops and
// the parser holds its state.
// Reset (aresetn low, synchronous): hunting for the first sync byte, output
// empty, registers back to their default values.
module sync_length_frame_deframer #(
    parameter int MAX_PAYLOAD = sld_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [sld_pkg::BYTE_W-1:0]     s_rx_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_item_kind,
    output logic [sld_pkg::BYTE_W-1:0]     m_payload_byte,
    output logic [sld_pkg::BYTE_W-1:0]     m_byte_index,
    output logic [sld_pkg::WORD_W-1:0]     m_command_id,
    output logic [sld_pkg::WORD_W-1:0]     m_frame_length,
    output logic [sld_pkg::STATUS_W-1:0]   m_frame_status,
    output logic                           m_frame_last,
    input  logic                           cfg_wr_en,
    input  logic [sld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sld_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import sld_pkg::*;

    cfg_t    cfg;
    result_t parse_res;
    result_t out_res;
    logic    parse_valid;
    logic    in_ready;

    assign s_ready = in_ready;

    sld_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    sld_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid && in_ready),
        .in_byte   (s_rx_byte),
        .cfg       (cfg),
        .res_valid (parse_valid),
        .res       (parse_res)
    );

    sld_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (parse_valid),
        .in_res    (parse_res),
        .in_ready  (in_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_item_kind    = out_res.item_kind;
    assign m_payload_byte = out_res.payload_byte;
    assign m_byte_index   = out_res.byte_index;
    assign m_command_id   = out_res.command_id;
    assign m_frame_length = out_res.frame_length;
    assign m_frame_status = out_res.frame_status;
    assign m_frame_last   = out_res.frame_last;

endmodule

// ===== tb/sv/tb_sync_length_frame_deframer.sv =====
`timescale 1ns / 1ps

module tb_sync_length_frame_deframer;
    import sld_pkg::*;

    localparam int PAYLOAD_CAP   = MAX_PAYLOAD_DEFAULT - 2;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int NO_LONG_FRAME = -1;
    localparam int PHASE_BEATS   = 90;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        PH_HUNT, PH_SYNC2, PH_CMD_LO, PH_CMD_HI, PH_LEN_LO, PH_LEN_HI,
        PH_PAYLOAD, PH_CHK_LO, PH_CHK_HI
    } parse_phase_e;

    class frame_tracker;
        cfg_t          regs;
        parse_phase_e  phase;
        logic [15:0]   cmd_word;
        logic [15:0]   len_word;
        int unsigned   taken;
        logic [7:0]    chk_lo;
        result_t       pending[$];
        int unsigned   fails;
        int unsigned   n_bytes;
        int unsigned   n_payload;
        int unsigned   n_good;
        int unsigned   n_bad;
        int unsigned   n_abort;

        function new();
            regs.sync_first     = SYNC_FIRST_RESET;
            regs.sync_second    = SYNC_SECOND_RESET;
            regs.check_expected = CHECK_EXPECTED_RESET;
            phase     = PH_HUNT;
            cmd_word  = '0;
            len_word  = '0;
            taken     = 0;
            chk_lo    = '0;
            fails     = 0;
            n_bytes   = 0;
            n_payload = 0;
            n_good    = 0;
            n_bad     = 0;
            n_abort   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SYNC_FIRST:     regs.sync_first = data[7:0];
                CFG_SYNC_SECOND:    regs.sync_second = data[7:0];
                CFG_CHECK_EXPECTED: regs.check_expected = data;
                default: ;
            endcase
        endfunction

        function void push_end(logic [STATUS_W-1:0] status);
            result_t r;
            r = '0;
            r.item_kind    = KIND_END;
            r.command_id   = cmd_word;
            r.frame_length = len_word;
            r.frame_status = status;
            r.frame_last   = 1'b1;
            pending.push_back(r);
            case (status)
                STATUS_GOOD:     n_good++;
                STATUS_MISMATCH: n_bad++;
                default:         n_abort++;
            endcase
        endfunction

        function void take_byte(logic [7:0] b);
            result_t r;
            n_bytes++;
            case (phase)
                PH_SYNC2: phase = (b == regs.sync_second) ? PH_CMD_LO : PH_HUNT;
                PH_CMD_LO: begin
                    cmd_word = {8'h00, b};
                    phase = PH_CMD_HI;
                end
                PH_CMD_HI: begin
                    cmd_word[15:8] = b;
                    phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_word = {8'h00, b};
                    phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    len_word[15:8] = b;
                    phase = (len_word == 16'd0) ? PH_CHK_LO : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (taken < len_word && taken < PAYLOAD_CAP) begin
                        r = '0;
                        r.item_kind    = KIND_DATA;
                        r.payload_byte = b;
                        r.byte_index   = taken[7:0];
                        pending.push_back(r);
                        n_payload++;
                        taken++;
                        if (taken == len_word) phase = PH_CHK_LO;
                    end else begin
                        // drop the overrun byte and go back to hunting
                        phase = PH_HUNT;
                        push_end(STATUS_ABORTED);
                    end
                end
                PH_CHK_LO: begin
                    chk_lo = b;
                    phase = PH_CHK_HI;
                end
                PH_CHK_HI: begin
                    phase = PH_HUNT;
                    push_end(({b, chk_lo} == regs.check_expected) ? STATUS_GOOD
                                                                  : STATUS_MISMATCH);
                end
                default: begin
                    if (b == regs.sync_first) begin
                        cmd_word = '0;
                        len_word = '0;
                        taken    = 0;
                        phase    = PH_SYNC2;
                    end else begin
                        phase = PH_HUNT;
                    end
                end
            endcase
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                fails++;
            end
        endfunction

        function void match_beat(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected (kind %0d)", got.item_kind);
                fails++;
                return;
            end
            want = pending.pop_front();
            check_field("item_kind", want.item_kind, got.item_kind);
            check_field("payload_byte", want.payload_byte, got.payload_byte);
            check_field("byte_index", want.byte_index, got.byte_index);
            check_field("command_id", want.command_id, got.command_id);
            check_field("frame_length", want.frame_length, got.frame_length);
            check_field("frame_status", want.frame_status, got.frame_status);
            check_field("frame_last", want.frame_last, got.frame_last);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_rx_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_item_kind;
    logic [BYTE_W-1:0]     m_payload_byte;
    logic [BYTE_W-1:0]     m_byte_index;
    logic [WORD_W-1:0]     m_command_id;
    logic [WORD_W-1:0]     m_frame_length;
    logic [STATUS_W-1:0]   m_frame_status;
    logic                  m_frame_last;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    frame_tracker trk;
    bit           src_calm = 1'b0;
    bit           snk_calm = 1'b0;

    sync_length_frame_deframer #(
        .MAX_PAYLOAD(MAX_PAYLOAD_DEFAULT)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item_kind(m_item_kind),
        .m_payload_byte(m_payload_byte),
        .m_byte_index(m_byte_index),
        .m_command_id(m_command_id),
        .m_frame_length(m_frame_length),
        .m_frame_status(m_frame_status),
        .m_frame_last(m_frame_last),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 49) == 0) src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        trk.take_byte(b);
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic [15:0] cmd, input logic [15:0] len,
                              input logic [15:0] chk);
        int n;
        n = (len > PAYLOAD_CAP) ? PAYLOAD_CAP + 1 : len;
        send_byte(trk.regs.sync_first);
        send_byte(trk.regs.sync_second);
        send_byte(cmd[7:0]);
        send_byte(cmd[15:8]);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        repeat (n) send_byte(8'($urandom));
        if (len <= PAYLOAD_CAP) begin
            send_byte(chk[7:0]);
            send_byte(chk[15:8]);
        end
    endtask

    function automatic logic [15:0] pick_check();
        return ($urandom_range(0, 9) < 6) ? trk.regs.check_expected : 16'($urandom);
    endfunction

    task automatic random_traffic(input int long_len);
        int unsigned stop_at;
        int          pick;
        logic [7:0]  bad;
        if (long_len != NO_LONG_FRAME) send_frame(16'($urandom), 16'(long_len), pick_check());
        stop_at = trk.n_bytes + PHASE_BEATS;
        while (trk.n_bytes < stop_at) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else if (pick == 1) begin
                bad = 8'($urandom);
                if (bad == trk.regs.sync_second) bad = ~bad;
                send_byte(trk.regs.sync_first);
                send_byte(bad);
            end else begin
                send_frame(16'($urandom),
                           ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12)),
                           pick_check());
            end
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        trk.write_reg(idx, data);
        @(negedge aclk);
    endtask

    // hold until every expected beat is back, then let the parser settle
    task automatic drain();
        s_valid <= 1'b0;
        while (trk.pending.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        result_t seen;
        int      gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 49) == 0) snk_calm = !snk_calm;
            gap = snk_calm ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            seen = {m_item_kind, m_payload_byte, m_byte_index, m_command_id,
                    m_frame_length, m_frame_status, m_frame_last};
            trk.match_beat(seen);
            @(negedge aclk);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb_sync_length_frame_deframer NOT OK");
        $finish;
    end

    initial begin
        logic [7:0] same_sync;
        trk = new();
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_rx_byte   = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: zero length, check mismatch, repeated first sync
        send_frame(16'hFFFF, 16'h0000, trk.regs.check_expected);
        send_frame(16'h0000, 16'h0001, ~trk.regs.check_expected);
        send_byte(trk.regs.sync_first);
        send_byte(trk.regs.sync_first);
        send_byte(trk.regs.sync_second);
        drain();
        random_traffic(NO_LONG_FRAME);
        drain();

        cfg_write(CFG_SYNC_FIRST, {8'($urandom), 8'h00});
        cfg_write(CFG_SYNC_SECOND, {8'($urandom), 8'hFF});
        cfg_write(CFG_CHECK_EXPECTED, 16'h0000);
        random_traffic(PAYLOAD_CAP);
        drain();

        cfg_write(CFG_SYNC_FIRST, 16'h00FF);
        cfg_write(CFG_SYNC_SECOND, 16'hFF00);
        cfg_write(CFG_CHECK_EXPECTED, 16'hFFFF);
        cfg_write(CFG_UNUSED, 16'($urandom));
        random_traffic($urandom_range(PAYLOAD_CAP + 1, 16'hFFFE));
        drain();

        cfg_write(CFG_SYNC_FIRST, 16'($urandom));
        cfg_write(CFG_SYNC_SECOND, 16'($urandom));
        cfg_write(CFG_CHECK_EXPECTED, 16'($urandom));
        cfg_write(CFG_UNUSED, 16'($urandom));
        random_traffic(16'hFFFF);
        drain();

        // both sync bytes equal
        same_sync = 8'($urandom);
        cfg_write(CFG_SYNC_FIRST, {8'h00, same_sync});
        cfg_write(CFG_SYNC_SECOND, {8'h00, same_sync});
        cfg_write(CFG_CHECK_EXPECTED, 16'($urandom));
        random_traffic(NO_LONG_FRAME);
        drain();

        $display("input beats %0d, payload beats %0d, across five register settings",
                 trk.n_bytes, trk.n_payload);
        $display("frames closed: %0d good, %0d check mismatch, %0d overrun aborts",
                 trk.n_good, trk.n_bad, trk.n_abort);
        if (trk.fails == 0 && trk.pending.size() == 0) begin
            $display("tb_sync_length_frame_deframer OK");
        end else begin
            $display("tb_sync_length_frame_deframer NOT OK");
        end
        $finish;
    end

endmodule
